@@ hdl/plf_pkg.sv @@
// shared types, constants and helpers for the playfair pair decrypter
package plf_pkg;

    localparam int SQ_DIM   = 5;
    localparam int CODE_W   = 5;
    localparam int POS_W    = 3;
    localparam int ROW_W    = SQ_DIM * CODE_W;
    localparam int CHAR_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_I     = 8'h49;
    localparam logic [CHAR_W-1:0] CHAR_J     = 8'h4A;
    localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;

    // register indexes of the key square rows
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_0 = 3'd0,
        REG_ROW_1 = 3'd1,
        REG_ROW_2 = 3'd2,
        REG_ROW_3 = 3'd3,
        REG_ROW_4 = 3'd4
    } cfg_reg_t;

    typedef logic [SQ_DIM-1:0][ROW_W-1:0] square_t;

    // a located letter
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

    // letter code held at (r, c), zero for positions outside the square
    function automatic logic [CODE_W-1:0] cell_at(input square_t sq,
                                                   input logic [POS_W-1:0] r,
                                                   input logic [POS_W-1:0] c);
        logic [ROW_W-1:0]  row_bits;
        logic [CODE_W-1:0] code;
        row_bits = '0;
        code     = '0;
        for (int i = 0; i < SQ_DIM; i++) begin
            if (r == POS_W'(i)) row_bits = sq[i];
        end
        for (int j = 0; j < SQ_DIM; j++) begin
            if (c == POS_W'(j)) code = row_bits[j*CODE_W +: CODE_W];
        end
        return code;
    endfunction

    // one step back with wrap around the square edge
    function automatic logic [POS_W-1:0] pos_back(input logic [POS_W-1:0] p);
        return (p == '0) ? POS_W'(SQ_DIM - 1) : POS_W'(p - 1'b1);
    endfunction

    // ascii letter for a square code
    function automatic logic [CHAR_W-1:0] code_char(input logic [CODE_W-1:0] code);
        return CHAR_W'(CHAR_A + {3'b000, code});
    endfunction

endpackage

@@ hdl/playfair_pair_decrypt.sv @@
// playfair decryption of a ciphertext stream, one plaintext pair per result
//
//  channel | direction | payload                                  | marker
//  s_      | in        | tdata[7:0] char_in                       | tlast end_of_message
//  m_      | out       | tdata[7:0] plain_first, [15:8] plain_second | tuser not_in_square
//  cfg_    | in        | wdata square row, index 0..4 selects row | none
//
// one request per cycle sustained while the output is not stalled; a character
// sits in the input register, where the 25 cell compares and the pair rules run,
// then the pair lands in the output register.
// aresetn (synchronous) empties both registers, drops any held letter and
// clears the square. a stalled output holds the input register, which still
// drains spaces and first letters that produce no result.
module playfair_pair_decrypt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] char_in
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [7:0] plain_first, [15:8] plain_second
    output logic [0:0]                    m_tuser,   // [0] not_in_square
    input  logic                          cfg_wr_en,
    input  logic [plf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plf_pkg::ROW_W-1:0]     cfg_wdata
);
    import plf_pkg::*;

    square_t             square_reg;
    logic                in_valid_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                in_last_reg;
    logic                pend_valid_reg;
    logic [POS_W-1:0]    pend_row_reg;
    logic [POS_W-1:0]    pend_col_reg;
    logic                pend_missing_reg;
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;
    logic                m_tuser_reg;

    logic [CHAR_W-1:0]   folded;
    logic                is_letter;
    logic [CODE_W-1:0]   code;
    pos_t                loc;
    logic                is_space;
    logic                makes_pair;
    logic                out_free;
    logic                in_adv;
    logic                out_load;
    logic                pair_missing;
    logic [POS_W-1:0]    ra, ca, rb, cb;
    logic [CODE_W-1:0]   code_a, code_b;

    // key square rows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            square_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ROW_0: square_reg[0] <= cfg_wdata;
                REG_ROW_1: square_reg[1] <= cfg_wdata;
                REG_ROW_2: square_reg[2] <= cfg_wdata;
                REG_ROW_3: square_reg[3] <= cfg_wdata;
                REG_ROW_4: square_reg[4] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // letter code with j folded onto i
    always_comb begin
        folded    = (in_char_reg == CHAR_J) ? CHAR_I : in_char_reg;
        is_letter = (folded >= CHAR_A) && (folded <= CHAR_Z);
        code      = CODE_W'(folded - CHAR_A);
    end

    // square search, scanned backwards so the first match in row order wins
    always_comb begin
        loc = '0;
        for (int r = SQ_DIM - 1; r >= 0; r--) begin
            for (int c = SQ_DIM - 1; c >= 0; c--) begin
                if (is_letter && square_reg[r][c*CODE_W +: CODE_W] == code) begin
                    loc.found = 1'b1;
                    loc.row   = POS_W'(r);
                    loc.col   = POS_W'(c);
                end
            end
        end
    end

    // playfair pair rules
    always_comb begin
        pair_missing = pend_missing_reg || !loc.found;
        if (pend_row_reg == loc.row) begin
            ra = pend_row_reg;
            ca = pos_back(pend_col_reg);
            rb = loc.row;
            cb = pos_back(loc.col);
        end else if (pend_col_reg == loc.col) begin
            ra = pos_back(pend_row_reg);
            ca = pend_col_reg;
            rb = pos_back(loc.row);
            cb = loc.col;
        end else begin
            ra = pend_row_reg;
            ca = loc.col;
            rb = loc.row;
            cb = pend_col_reg;
        end
        code_a = cell_at(square_reg, ra, ca);
        code_b = cell_at(square_reg, rb, cb);
    end

    // handshake between the two registers
    assign is_space   = (in_char_reg == CHAR_SPACE);
    assign makes_pair = in_valid_reg && !is_space && pend_valid_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign in_adv     = in_valid_reg && (!makes_pair || out_free);
    assign out_load   = makes_pair && out_free;
    assign s_tready   = !in_valid_reg || in_adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // held first letter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg   <= 1'b0;
            pend_row_reg     <= '0;
            pend_col_reg     <= '0;
            pend_missing_reg <= 1'b0;
        end else if (in_adv) begin
            if (in_last_reg || makes_pair) begin
                pend_valid_reg   <= 1'b0;
                pend_row_reg     <= '0;
                pend_col_reg     <= '0;
                pend_missing_reg <= 1'b0;
            end else if (!is_space) begin
                pend_valid_reg   <= 1'b1;
                pend_row_reg     <= loc.row;
                pend_col_reg     <= loc.col;
                pend_missing_reg <= !loc.found;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= pair_missing ? 16'h0000 : {code_char(code_b), code_char(code_a)};
            m_tuser_reg <= pair_missing;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // a flagged pair carries no letters
    a_missing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'h0000)
        else $error("flagged pair carries letters");

    // letters come from codes 0..31, so 'A' up to 'A'+31
    a_letter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[7:0] >= 8'h41) && (m_tdata[7:0] <= 8'h60)
                                 && (m_tdata[15:8] >= 8'h41) && (m_tdata[15:8] <= 8'h60))
        else $error("plaintext byte outside letter range");

    // an end marker leaves no held letter
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_adv && in_last_reg |=> !pend_valid_reg)
        else $error("held letter survives end of message");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

@@ bench/plf_pair_checker.sv @@
// checker for the playfair pair decrypter: predicts plaintext pairs and compares results
`timescale 1ns / 1ps

module plf_pair_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] char_in
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [15:0]                   m_tdata,   // [7:0] plain_first, [15:8] plain_second
    input  logic [0:0]                    m_tuser,   // [0] not_in_square
    input  logic                          cfg_wr_en,
    input  logic [plf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plf_pkg::ROW_W-1:0]     cfg_wdata,
    output int                            n_pending,
    output int                            n_fail
);
    import plf_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] first;
        logic [CHAR_W-1:0] second;
        logic              missing;
    } plain_pair_t;

    // local copy of the key square and the held first letter
    square_t           key_rows;
    logic              held_valid;
    logic [POS_W-1:0]  held_row;
    logic [POS_W-1:0]  held_col;
    logic              held_missing;

    plain_pair_t       expected_pairs[$];
    int                mismatches = 0;

    task automatic report(input string what);
        $display("%0t checker: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [CODE_W-1:0] square_code(input int r, input int c);
        return key_rows[r][c*CODE_W +: CODE_W];
    endfunction

    // scan rows then columns, first match wins; j folds onto i
    task automatic find_letter(input logic [CHAR_W-1:0] ch, output logic found,
                               output logic [POS_W-1:0] row,
                               output logic [POS_W-1:0] col);
        logic [CHAR_W-1:0] folded;
        folded = (ch == CHAR_J) ? CHAR_I : ch;
        found  = 1'b0;
        row    = '0;
        col    = '0;
        if (folded >= CHAR_A && folded <= CHAR_Z) begin
            for (int r = 0; r < SQ_DIM; r++) begin
                for (int c = 0; c < SQ_DIM; c++) begin
                    if (!found && square_code(r, c) == CODE_W'(folded - CHAR_A)) begin
                        found = 1'b1;
                        row   = POS_W'(r);
                        col   = POS_W'(c);
                    end
                end
            end
        end
    endtask

    task automatic drop_held();
        held_valid   = 1'b0;
        held_row     = '0;
        held_col     = '0;
        held_missing = 1'b0;
    endtask

    // one accepted character: hold a first letter or decrypt a completed pair
    task automatic take_char(input logic [CHAR_W-1:0] ch, input logic eom);
        logic              found;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [CODE_W-1:0] a;
        logic [CODE_W-1:0] b;
        int                r1;
        int                c1;
        int                r2;
        int                c2;
        plain_pair_t       pair;
        if (ch != CHAR_SPACE) begin
            find_letter(ch, found, row, col);
            if (!held_valid) begin
                held_valid   = 1'b1;
                held_row     = row;
                held_col     = col;
                held_missing = !found;
            end else begin
                pair         = '0;
                pair.missing = held_missing || !found;
                r1 = int'(held_row);
                c1 = int'(held_col);
                r2 = int'(row);
                c2 = int'(col);
                if (!pair.missing) begin
                    if (r1 == r2) begin
                        // same row, also covers two letters on one cell
                        a = square_code(r1, (c1 + SQ_DIM - 1) % SQ_DIM);
                        b = square_code(r2, (c2 + SQ_DIM - 1) % SQ_DIM);
                    end else if (c1 == c2) begin
                        a = square_code((r1 + SQ_DIM - 1) % SQ_DIM, c1);
                        b = square_code((r2 + SQ_DIM - 1) % SQ_DIM, c2);
                    end else begin
                        a = square_code(r1, c2);
                        b = square_code(r2, c1);
                    end
                    pair.first  = CHAR_W'(CHAR_A + CHAR_W'(a));
                    pair.second = CHAR_W'(CHAR_A + CHAR_W'(b));
                end
                expected_pairs.push_back(pair);
                drop_held();
            end
        end
        // end of message drops an unpaired letter
        if (eom) drop_held();
    endtask

    task automatic check_pair();
        plain_pair_t want;
        if (expected_pairs.size() == 0) begin
            report($sformatf("pair %h flag %b with nothing expected", m_tdata, m_tuser));
        end else begin
            want = expected_pairs.pop_front();
            if (m_tdata[7:0] !== want.first)
                report($sformatf("plain_first %h, expected %h", m_tdata[7:0], want.first));
            if (m_tdata[15:8] !== want.second)
                report($sformatf("plain_second %h, expected %h", m_tdata[15:8], want.second));
            if (m_tuser[0] !== want.missing)
                report($sformatf("not_in_square %b, expected %b", m_tuser[0], want.missing));
        end
    endtask

    // watch config writes, requests and results
    always @(posedge aclk) begin
        if (!aresetn) begin
            key_rows = '0;
            drop_held();
            expected_pairs.delete();
        end else begin
            if (cfg_wr_en && cfg_index <= REG_ROW_4) key_rows[cfg_index] = cfg_wdata;
            if (s_tvalid && s_tready) take_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready) check_pair();
        end
        n_pending <= expected_pairs.size();
        n_fail    <= mismatches;
    end

endmodule

@@ bench/tb.sv @@
// testbench top for the playfair pair decrypter: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb;
    import plf_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 5000;
    localparam int CHUNK_ITEMS  = 200;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0]     cfg_wdata = '0;

    int                   n_pending;
    int                   n_fail;
    int                   tx_idle_pct = 15;
    int                   rx_idle_pct = 85;
    logic                 hold_toggle = 1'b0;
    logic                 hold_seen   = 1'b0;
    int                   hold_left   = 0;
    int                   stuck_cycles = 0;

    always #10 aclk = ~aclk;

    playfair_pair_decrypt dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    plf_pair_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .n_pending (n_pending),
        .n_fail    (n_fail)
    );

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // one request, with random gaps in front of it
    task automatic send(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending and wait until every expected pair has been received, then idle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_square(input square_t sq);
        for (int i = 0; i < SQ_DIM; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_wdata <= sq[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // the 25 letters without j, in order or shuffled
    function automatic square_t letter_square(input logic mix);
        logic [CODE_W-1:0] codes[SQ_DIM*SQ_DIM];
        logic [CODE_W-1:0] t;
        int                n;
        int                j;
        square_t           sq;
        n = 0;
        for (int c = 0; c <= int'(CHAR_Z - CHAR_A); c++) begin
            if (c != int'(CHAR_J - CHAR_A)) begin
                codes[n] = CODE_W'(c);
                n++;
            end
        end
        if (mix) begin
            for (int i = SQ_DIM*SQ_DIM - 1; i > 0; i--) begin
                j        = $urandom_range(i);
                t        = codes[i];
                codes[i] = codes[j];
                codes[j] = t;
            end
        end
        for (int i = 0; i < SQ_DIM*SQ_DIM; i++)
            sq[i / SQ_DIM][(i % SQ_DIM)*CODE_W +: CODE_W] = codes[i];
        return sq;
    endfunction

    // mostly letters held in the square, some other letters, spaces and noise
    function automatic logic [7:0] pick_char(input square_t sq);
        logic [CODE_W-1:0] code;
        logic [7:0]        ch;
        int                roll;
        int                r;
        int                c;
        roll = $urandom_range(99);
        r    = $urandom_range(SQ_DIM - 1);
        c    = $urandom_range(SQ_DIM - 1);
        code = sq[r][c*CODE_W +: CODE_W];
        if (roll < 70) begin
            ch = 8'(CHAR_A + 8'(code));
            if (ch == CHAR_I && $urandom_range(1)) ch = CHAR_J;
        end else if (roll < 80) begin
            ch = 8'($urandom_range(CHAR_Z, CHAR_A));
        end else if (roll < 88) begin
            ch = CHAR_SPACE;
        end else begin
            ch = 8'($urandom_range(255));
        end
        return ch;
    endfunction

    initial begin
        square_t sq;
        int      chunk;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // square left at reset: every cell is a
        send("A", 1'b0);
        send("A", 1'b0);
        send("A", 1'b0);
        send(CHAR_SPACE, 1'b0);
        send("B", 1'b0);
        send(8'h00, 1'b0);
        send(8'hFF, 1'b0);
        settle();

        // ordered square, one case per rule
        write_square(letter_square(1'b0));
        send("A", 1'b0);
        send("E", 1'b0);
        send("A", 1'b0);
        send("V", 1'b0);
        send("H", 1'b0);
        send("Y", 1'b0);
        send("J", 1'b0);
        send("I", 1'b0);
        send("a", 1'b0);
        send("B", 1'b0);
        send("C", 1'b1);
        send("D", 1'b0);
        send(CHAR_SPACE, 1'b1);
        send("E", 1'b0);
        send("F", 1'b1);

        // random messages in three idling phases
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 15 : (p == 1) ? 85 : 0;
            rx_idle_pct <= (p == 0) ? 85 : (p == 1) ? 15 : 0;
            for (int k = 0; k < 3; k++) begin
                chunk = p * 3 + k;
                settle();
                if (chunk == 2 || chunk == 7) begin
                    // raw codes: duplicates and codes past z
                    for (int i = 0; i < SQ_DIM; i++) sq[i] = ROW_W'($urandom);
                end else if (chunk == 5) begin
                    sq = '1;
                end else begin
                    sq = letter_square(1'b1);
                end
                write_square(sq);
                for (int n = 0; n < CHUNK_ITEMS; n++) begin
                    if (p == 2 && k == 0 && n == 20) hold_toggle <= ~hold_toggle;
                    if (p == 0 && k == 1 && n == 100) settle();
                    send(pick_char(sq), ($urandom_range(11) == 0));
                end
            end
        end

        settle();
        repeat (4) @(posedge aclk);
        if (n_fail == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
